// File: hw/rtl/gce_pkg.sv
// Shared constants, types and helper functions of the grayscale cross erosion block.
// No dependencies; every other RTL file except gce_ram imports this package.
`default_nettype none

package gce_pkg;

   // Frame limits and field widths.
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int PIX_W = 8;
   localparam int CFG_W = 11;
   localparam int COLUMNS_RESET = 1024;
   localparam int ROWS_RESET = 1024;

   // Pixel window: two rows plus one pixel, addressed by raster index modulo depth.
   localparam int WIN_DEPTH = 2 * MAX_COLUMNS + 1;
   localparam int SLOT_W = $clog2(WIN_DEPTH);

   // Pixel counters must hold the frame size itself.
   localparam int TOTAL_W = $clog2(MAX_COLUMNS * MAX_ROWS + 1);

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd1;

   // Item opcodes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Neighbour positions.
   localparam int NB_COUNT = 4;
   localparam int NB_NORTH = 0;
   localparam int NB_SOUTH = 1;
   localparam int NB_EAST = 2;
   localparam int NB_WEST = 3;

   typedef struct packed {
      logic [PIX_W-1:0] north;
      logic [PIX_W-1:0] south;
      logic [PIX_W-1:0] east;
      logic [PIX_W-1:0] west;
      logic             frame_last;
   } gce_operands_type;

   function automatic logic [CFG_W-1:0] clamp_columns(input logic [CFG_W-1:0] value);
      logic [CFG_W-1:0] used;
      used = value;
      if (value == '0) begin
         used = CFG_W'(1);
      end else if (int'(value) > MAX_COLUMNS) begin
         used = CFG_W'(MAX_COLUMNS);
      end
      return used;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_rows(input logic [CFG_W-1:0] value);
      logic [CFG_W-1:0] used;
      used = value;
      if (value == '0) begin
         used = CFG_W'(1);
      end else if (int'(value) > MAX_ROWS) begin
         used = CFG_W'(MAX_ROWS);
      end
      return used;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gce_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies; read returns the contents from before a write in the same cycle.
`default_nettype none

module gce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gce_front.sv
// Front part: configuration registers, frame counters, item classification and
// the pixel window (two gce_ram copies). Produces one operand record per result.
`default_nettype none

module gce_front import gce_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic                  req_opcode,
   input  wire logic [PIX_W-1:0]      req_pixel_in,
   output logic                       full,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_write_data,
   input  wire logic [QCNT_W-1:0]     q_level,
   output logic                       q_push,
   output gce_operands_type           q_data
);

   localparam int W1 = TOTAL_W + 1;

   logic [CFG_W-1:0]   cols_ff, cols_in, rows_ff, rows_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] rcv_ff, rcv_in, emit_ff, emit_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in, eslot_ff, eslot_in;
   logic [PIX_W-1:0]   first_ff, first_in, last_ff, last_in;

   logic                              s1_valid_ff, s1_valid_in;
   logic [NB_COUNT-1:0]               s1_fix_ff, s1_fix_in;
   logic [NB_COUNT-1:0][PIX_W-1:0]    s1_val_ff, s1_val_in;
   logic                              s1_last_ff, s1_last_in;

   logic [CFG_W-1:0]     mul_a, mul_b;
   logic [2*CFG_W-1:0]   product;
   logic                 accept, store, push_fire, flush_ok, flush_fire, flush_wrap, fire;
   logic                 is_final, last_ok;
   logic [W1-1:0]        j_w, c_w, total_w, rcv_w, rcv_upd_w, s_sum;
   logic                 s_clamp, e_clamp;
   logic [SLOT_W-1:0]    s_off, e_off;
   logic [NB_COUNT-1:0]  k_zero, k_end;
   logic [NB_COUNT-1:0][SLOT_W-1:0] slot;
   logic [PIX_W-1:0]     ram_n, ram_s, ram_e, ram_w;

   function automatic logic [SLOT_W-1:0] slot_fwd(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W-1:0] off);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (SLOT_W+1)'(WIN_DEPTH)) begin
         sum = sum - (SLOT_W+1)'(WIN_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W-1:0] off);
      logic [SLOT_W-1:0] diff;
      if (base >= off) begin
         diff = base - off;
      end else begin
         diff = SLOT_W'(WIN_DEPTH) - off + base;
      end
      return diff;
   endfunction

   // Frame size follows every register write, so an item may come right after it.
   always_comb begin
      mul_a = cols_ff;
      mul_b = rows_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COLUMNS: mul_a = clamp_columns(csr_write_data);
            CSR_ROWS:    mul_b = clamp_rows(csr_write_data);
            default:     ;
         endcase
      end
      product = mul_a * mul_b;
      cols_in = mul_a;
      rows_in = mul_b;
      total_in = TOTAL_W'(product);
   end

   assign full = ({1'b0, q_level} + (QCNT_W+1)'(s1_valid_ff)) >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept = push && !full;

   assign j_w = {1'b0, emit_ff};
   assign c_w = W1'(cols_ff);
   assign total_w = {1'b0, total_ff};
   assign rcv_w = {1'b0, rcv_ff};
   assign s_sum = j_w + c_w;

   // Classification of the item against the frame counters.
   always_comb begin
      store = accept && (req_opcode == OP_PIXEL) && (rcv_ff < total_ff);
      push_fire = store && (s_sum <= rcv_w) && (emit_ff < total_ff);
      flush_ok = accept && (req_opcode == OP_FLUSH) && (rcv_ff >= total_ff);
      flush_fire = flush_ok && (emit_ff < total_ff);
      flush_wrap = flush_ok && (emit_ff >= total_ff);
      fire = push_fire || flush_fire;
      is_final = (j_w + W1'(1)) == total_w;
      rcv_upd_w = store ? rcv_w + W1'(1) : rcv_w;
      last_ok = rcv_upd_w == total_w;
      first_in = (store && rcv_ff == '0) ? req_pixel_in : first_ff;
      last_in = store ? req_pixel_in : last_ff;
   end

   // Neighbour indexes, clamped in the flat raster, and their window slots.
   always_comb begin
      s_clamp = s_sum >= total_w;
      e_clamp = (j_w + W1'(1)) >= total_w;
      s_off = s_clamp ? SLOT_W'(total_ff - TOTAL_W'(1) - emit_ff) : SLOT_W'(cols_ff);
      e_off = e_clamp ? '0 : SLOT_W'(1);

      k_zero[NB_NORTH] = j_w <= c_w;
      k_zero[NB_WEST] = emit_ff <= TOTAL_W'(1);
      k_zero[NB_SOUTH] = s_clamp && (total_ff == TOTAL_W'(1));
      k_zero[NB_EAST] = e_clamp && (total_ff == TOTAL_W'(1));

      // North and west always lie before the last pixel of the frame.
      k_end[NB_NORTH] = 1'b0;
      k_end[NB_WEST] = 1'b0;
      k_end[NB_SOUTH] = (s_sum + W1'(1)) >= total_w;
      k_end[NB_EAST] = (j_w + W1'(2)) >= total_w;

      slot[NB_NORTH] = slot_back(eslot_ff, SLOT_W'(cols_ff));
      slot[NB_WEST] = slot_back(eslot_ff, SLOT_W'(1));
      slot[NB_SOUTH] = slot_fwd(eslot_ff, s_off);
      slot[NB_EAST] = slot_fwd(eslot_ff, e_off);

      // A neighbour is taken from a register when it is the first or last pixel,
      // or when its slot is being written by this very item.
      for (int n = 0; n < NB_COUNT; n++) begin
         s1_fix_in[n] = 1'b0;
         s1_val_in[n] = req_pixel_in;
         if (k_zero[n]) begin
            s1_fix_in[n] = 1'b1;
            s1_val_in[n] = first_in;
         end else if (k_end[n] && last_ok) begin
            s1_fix_in[n] = 1'b1;
            s1_val_in[n] = last_in;
         end else if (store && slot[n] == rslot_ff) begin
            s1_fix_in[n] = 1'b1;
            s1_val_in[n] = req_pixel_in;
         end
      end
      s1_valid_in = fire;
      s1_last_in = is_final;
   end

   // Counter and slot update.
   always_comb begin
      rcv_in = rcv_ff;
      rslot_in = rslot_ff;
      emit_in = emit_ff;
      eslot_in = eslot_ff;
      if (store) begin
         rcv_in = rcv_ff + TOTAL_W'(1);
         rslot_in = (rslot_ff == SLOT_W'(WIN_DEPTH - 1)) ? '0 : rslot_ff + SLOT_W'(1);
      end
      if (fire) begin
         emit_in = emit_ff + TOTAL_W'(1);
         eslot_in = (eslot_ff == SLOT_W'(WIN_DEPTH - 1)) ? '0 : eslot_ff + SLOT_W'(1);
      end
      if ((fire && is_final) || flush_wrap) begin
         rcv_in = '0;
         rslot_in = '0;
         emit_in = '0;
         eslot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= clamp_columns(CFG_W'(COLUMNS_RESET));
         rows_ff <= clamp_rows(CFG_W'(ROWS_RESET));
         total_ff <= TOTAL_W'(int'(clamp_columns(CFG_W'(COLUMNS_RESET))) *
                              int'(clamp_rows(CFG_W'(ROWS_RESET))));
         rcv_ff <= '0;
         emit_ff <= '0;
         rslot_ff <= '0;
         eslot_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         total_ff <= total_in;
         rcv_ff <= rcv_in;
         emit_ff <= emit_in;
         rslot_ff <= rslot_in;
         eslot_ff <= eslot_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff <= last_in;
      s1_fix_ff <= s1_fix_in;
      s1_val_ff <= s1_val_in;
      s1_last_ff <= s1_last_in;
   end

   // Two identical window copies give four reads per cycle.
   gce_ram #(
      .WIDTH (PIX_W),
      .DEPTH (WIN_DEPTH)
   ) u_window_ns (
      .clock     (clock),
      .wr_en     (store),
      .wr_addr   (rslot_ff),
      .wr_data   (req_pixel_in),
      .rd_addr_a (slot[NB_NORTH]),
      .rd_addr_b (slot[NB_SOUTH]),
      .rd_data_a (ram_n),
      .rd_data_b (ram_s)
   );

   gce_ram #(
      .WIDTH (PIX_W),
      .DEPTH (WIN_DEPTH)
   ) u_window_ew (
      .clock     (clock),
      .wr_en     (store),
      .wr_addr   (rslot_ff),
      .wr_data   (req_pixel_in),
      .rd_addr_a (slot[NB_EAST]),
      .rd_addr_b (slot[NB_WEST]),
      .rd_data_a (ram_e),
      .rd_data_b (ram_w)
   );

   always_comb begin
      q_push = s1_valid_ff;
      q_data.north = s1_fix_ff[NB_NORTH] ? s1_val_ff[NB_NORTH] : ram_n;
      q_data.south = s1_fix_ff[NB_SOUTH] ? s1_val_ff[NB_SOUTH] : ram_s;
      q_data.east = s1_fix_ff[NB_EAST] ? s1_val_ff[NB_EAST] : ram_e;
      q_data.west = s1_fix_ff[NB_WEST] ? s1_val_ff[NB_WEST] : ram_w;
      q_data.frame_last = s1_last_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/gce_fifo.sv
// Short register queue of operand records between the front and back parts.
// Depends on gce_pkg for the record type and the depth.
`default_nettype none

module gce_fifo import gce_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gce_operands_type  push_data,
   input  wire logic              pop,
   output gce_operands_type       head,
   output logic                   not_empty,
   output logic [QCNT_W-1:0]      level
);

   gce_operands_type storage_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = storage_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign level = count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gce_back.sv
// Back part: takes operand records from the queue, forms the minimum of the four
// neighbours and holds the result in the output register. Depends on gce_pkg.
`default_nettype none

module gce_back import gce_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire gce_operands_type  q_data,
   output logic                   q_pop,
   input  wire logic              pop,
   output logic                   empty,
   output logic [PIX_W-1:0]       rsp_eroded_pixel,
   output logic                   rsp_frame_last
);

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_pixel_ff, out_pixel_in;
   logic             out_last_ff, out_last_in;
   logic [PIX_W-1:0] min_ns, min_ew;
   logic             load;

   always_comb begin
      min_ns = (q_data.north < q_data.south) ? q_data.north : q_data.south;
      min_ew = (q_data.east < q_data.west) ? q_data.east : q_data.west;
      out_pixel_in = (min_ns < min_ew) ? min_ns : min_ew;
      out_last_in = q_data.frame_last;

      // The output register refills in the same cycle that its item is taken.
      load = q_valid && (!out_valid_ff || pop);
      out_valid_in = load || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pixel_ff <= out_pixel_in;
         out_last_ff <= out_last_in;
      end
   end

   assign q_pop = load;
   assign empty = !out_valid_ff;
   assign rsp_eroded_pixel = out_pixel_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/grayscale_cross_erosion.sv
// Top level of the streaming 4-neighbour grayscale erosion block.
// Depends on gce_pkg, gce_front (with gce_ram), gce_fifo and gce_back.
`default_nettype none

// Pixels enter in raster order, one item per clock while full is low, and each output pixel
// is the minimum of its north, south, east and west neighbours in the flat raster, with
// indexes clamped to the first and last pixel of the frame. The output for pixel i leaves
// when pixel i + columns arrives; the rest of the frame is drained by flush items, and
// frame_last marks the final output. Both sides sustain one item per clock while full is
// low and pop is held: the window is kept in two identical RAM copies, each with one write
// port and two read ports, which together serve the four neighbour reads and the pixel
// write of every item. A result passes through the read stage, the queue and the output
// register, and full rises once the four-entry queue and the read stage in front of it
// together hold four items. The window needs no clearing after reset, since every slot
// that an output reads is written earlier in the same frame. The user must see that columns
// and rows are written through the csr port only while no item is in flight; the block does
// not enforce this. Zero counts as one and values above the maximum count as the maximum.
module grayscale_cross_erosion import gce_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic                 req_opcode,
   input  wire logic [PIX_W-1:0]     req_pixel_in,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [PIX_W-1:0]          rsp_eroded_pixel,
   output logic                      rsp_frame_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data
);

   logic              q_push, q_pop, q_not_empty;
   gce_operands_type  q_in, q_head;
   logic [QCNT_W-1:0] q_level;

   gce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_opcode       (req_opcode),
      .req_pixel_in     (req_pixel_in),
      .full             (full),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_level          (q_level),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   gce_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .level     (q_level)
   );

   gce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_data           (q_head),
      .q_pop            (q_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_eroded_pixel (rsp_eroded_pixel),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

`default_nettype wire

// File: verif/erosion_checker.sv
// Scoreboard for the grayscale cross erosion block: watches the item, result and register ports.
// Keeps its own copy of the frame state and checks every result in order.
// Depends on gce_pkg for widths, opcodes and register indexes.
`timescale 1ns / 100ps

module erosion_checker import gce_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic                 full,
   input  wire logic                 req_opcode,
   input  wire logic [PIX_W-1:0]     req_pixel_in,
   input  wire logic                 empty,
   input  wire logic                 pop,
   input  wire logic [PIX_W-1:0]     rsp_eroded_pixel,
   input  wire logic                 rsp_frame_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   output int                        error_count,
   output int                        outstanding
);

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic             frame_end;
   } eroded_item_type;

   logic [CFG_W-1:0] columns_reg;
   logic [CFG_W-1:0] rows_reg;
   logic [PIX_W-1:0] window [WIN_DEPTH];
   logic [PIX_W-1:0] frame_first;
   logic [PIX_W-1:0] frame_latest;
   int unsigned      frame_received;
   int unsigned      frame_emitted;
   eroded_item_type  pending_minima [$];
   eroded_item_type  oldest;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   task automatic report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic int unsigned used_columns();
      if (columns_reg == '0) return 1;
      if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return 32'(columns_reg);
   endfunction

   function automatic int unsigned used_rows();
      if (rows_reg == '0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return 32'(rows_reg);
   endfunction

   function automatic logic [PIX_W-1:0] lesser(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // The first pixel and, once the frame is in, the last one are held apart from the window.
   function automatic logic [PIX_W-1:0] neighbour(int unsigned k, int unsigned total);
      if (k == 0) return frame_first;
      if (k == total - 1 && frame_received == total) return frame_latest;
      return window[SLOT_W'(k % WIN_DEPTH)];
   endfunction

   function automatic logic [PIX_W-1:0] cross_minimum(int unsigned j, int unsigned c,
                                                      int unsigned total);
      int unsigned north;
      int unsigned south;
      int unsigned east;
      int unsigned west;
      logic [PIX_W-1:0] m;
      north = (j < c) ? 0 : j - c;
      west = (j < 1) ? 0 : j - 1;
      south = (j + c >= total) ? total - 1 : j + c;
      east = (j + 1 >= total) ? total - 1 : j + 1;
      m = lesser(neighbour(north, total), neighbour(south, total));
      m = lesser(m, neighbour(east, total));
      return lesser(m, neighbour(west, total));
   endfunction

   task automatic predict_erosion(logic op, logic [PIX_W-1:0] px);
      int unsigned c;
      int unsigned total;
      int unsigned i;
      int unsigned j;
      logic emit;
      eroded_item_type item;
      c = used_columns();
      total = c * used_rows();
      emit = 1'b0;
      j = frame_emitted;
      if (op == OP_PIXEL) begin
         i = frame_received;
         // Pixels past the end of the frame are dropped.
         if (i < total) begin
            window[SLOT_W'(i % WIN_DEPTH)] = px;
            if (i == 0) frame_first = px;
            frame_latest = px;
            frame_received = i + 1;
            if (i >= c && j + c <= i && j < total) emit = 1'b1;
         end
      end else if (frame_received >= total) begin
         // A frame shrunk below what was already emitted simply restarts.
         if (j >= total) begin
            frame_received = 0;
            frame_emitted = 0;
         end else begin
            emit = 1'b1;
         end
      end
      if (emit) begin
         item.level = cross_minimum(j, c, total);
         item.frame_end = (j + 1 == total);
         pending_minima.push_back(item);
         frame_emitted = j + 1;
         if (j + 1 == total) begin
            frame_received = 0;
            frame_emitted = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         columns_reg = CFG_W'(COLUMNS_RESET);
         rows_reg = CFG_W'(ROWS_RESET);
         for (int k = 0; k < WIN_DEPTH; k++) window[SLOT_W'(k)] = '0;
         frame_first = '0;
         frame_latest = '0;
         frame_received = 0;
         frame_emitted = 0;
         pending_minima.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_COLUMNS) columns_reg = csr_write_data;
            else if (csr_index == CSR_ROWS) rows_reg = csr_write_data;
         end
         if (push && !full) predict_erosion(req_opcode, req_pixel_in);
         if (pop && !empty) begin
            if (pending_minima.size() == 0) begin
               report($sformatf("result %0d/%0d with no item waiting",
                                rsp_eroded_pixel, rsp_frame_last));
            end else begin
               oldest = pending_minima.pop_front();
               if (rsp_eroded_pixel !== oldest.level) begin
                  report($sformatf("eroded_pixel %0d, expected %0d",
                                   rsp_eroded_pixel, oldest.level));
               end
               if (rsp_frame_last !== oldest.frame_end) begin
                  report($sformatf("frame_last %0b, expected %0b",
                                   rsp_frame_last, oldest.frame_end));
               end
            end
         end
      end
      outstanding <= pending_minima.size();
   end

endmodule

// File: verif/grayscale_cross_erosion_tb.sv
// Top of the grayscale cross erosion testbench: clock, reset, stimulus and the verdict.
// Depends on gce_pkg, the grayscale_cross_erosion block and erosion_checker.
`timescale 1ns / 100ps

module grayscale_cross_erosion_tb;
   import gce_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT_NS = 20_000_000;
   localparam logic [PIX_W-1:0] EDGE_PIXELS [6] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd77};

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 req_opcode = OP_PIXEL;
   logic [PIX_W-1:0]     req_pixel_in = '0;
   logic                 pop = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLUMNS;
   logic [CFG_W-1:0]     csr_write_data = '0;
   wire                  full;
   wire                  empty;
   wire [PIX_W-1:0]      rsp_eroded_pixel;
   wire                  rsp_frame_last;
   int                   failures;
   int                   pending;

   logic hold_off_request = 1'b0;
   bit   hold_off_done = 1'b0;
   bit   gaps_on = 1'b1;
   int   random_items = 0;

   grayscale_cross_erosion dut (
      .clock, .reset, .push, .full, .req_opcode, .req_pixel_in,
      .empty, .pop, .rsp_eroded_pixel, .rsp_frame_last,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   erosion_checker scoreboard (
      .clock, .reset, .push, .full, .req_opcode, .req_pixel_in,
      .empty, .pop, .rsp_eroded_pixel, .rsp_frame_last,
      .csr_write_enable, .csr_index, .csr_write_data,
      .error_count(failures), .outstanding(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("** grayscale_cross_erosion: FAILED **");
      $finish;
   end

   // Mostly no gap, now and then a short one, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return PIX_W'($urandom_range(255));
   endfunction

   task automatic send_item(logic op, logic [PIX_W-1:0] px);
      push <= 1'b1;
      req_opcode <= op;
      req_pixel_in <= px;
      do @(posedge clock); while (full);
   endtask

   task automatic offer(logic op, logic [PIX_W-1:0] px);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_item(op, px);
   endtask

   // Wait until every expected result is out, then give in-flight items time to finish.
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic configure(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
      settle();
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, rows);
      csr_write_enable <= 1'b0;
   endtask

   // One frame followed by the flush items that drain it; a noisy frame may also carry
   // early flushes, a pixel past the end and a stray flush once the frame is done.
   task automatic send_frame(int cols_used, int frame_size, bit noisy);
      for (int k = 0; k < frame_size; k++) begin
         if (noisy && $urandom_range(15) == 0) offer(OP_FLUSH, pick_pixel());
         offer(OP_PIXEL, pick_pixel());
      end
      if (noisy && $urandom_range(1) == 0) offer(OP_PIXEL, pick_pixel());
      repeat (cols_used) offer(OP_FLUSH, pick_pixel());
      if (noisy && $urandom_range(1) == 0) offer(OP_FLUSH, pick_pixel());
   endtask

   // Result side: random stalls, some steady stretches, and one long hold-off that
   // lets the block fill up while the sender keeps pushing.
   initial begin
      int gap;
      int steady_left;
      steady_left = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            if (steady_left > 0) begin
               steady_left--;
               gap = 0;
            end else begin
               gap = pick_gap();
               if ($urandom_range(31) == 0) steady_left = $urandom_range(30, 80);
            end
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int cols;
      int rows;
      int cols_used;
      int rows_used;
      int frames;
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Zero registers mean a one-pixel frame: early flush, stored pixel, dropped pixel,
      // the single result, then a flush on an empty frame.
      configure(11'd0, 11'd0);
      offer(OP_FLUSH, 8'h00);
      offer(OP_PIXEL, 8'hFF);
      offer(OP_PIXEL, 8'h07);
      offer(OP_FLUSH, 8'hFF);
      offer(OP_FLUSH, 8'h5A);

      configure(11'd3, 11'd2);
      foreach (EDGE_PIXELS[k]) offer(OP_PIXEL, EDGE_PIXELS[k]);
      repeat (3) offer(OP_FLUSH, pick_pixel());

      // Shrink the frame below what was already emitted; the next flush restarts it.
      configure(11'd2, 11'd3);
      offer(OP_PIXEL, 8'd200);
      offer(OP_PIXEL, 8'd3);
      offer(OP_PIXEL, 8'd255);
      offer(OP_PIXEL, 8'd90);
      settle();
      write_reg(CSR_ROWS, 11'd1);
      csr_write_enable <= 1'b0;
      offer(OP_FLUSH, 8'hA5);
      offer(OP_PIXEL, 8'd9);
      offer(OP_PIXEL, 8'd200);
      repeat (2) offer(OP_FLUSH, pick_pixel());

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         gaps_on = (phase % 4 != 3);
         if (phase == 2) begin
            // Widest rows over three rows, so window slots wrap around.
            configure(11'd1024, 11'd3);
            send_frame(MAX_COLUMNS, 3 * MAX_COLUMNS, 1'b0);
         end else if (phase == 5) begin
            configure(11'd1, 11'd2047);
            send_frame(1, MAX_ROWS, 1'b0);
         end else begin
            if (phase == 0) begin
               cols = 4;
               rows = 5;
               frames = 3;
            end else begin
               cols = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
               rows = $urandom_range(0, 5);
               frames = $urandom_range(1, 3);
            end
            configure(CFG_W'(cols), CFG_W'(rows));
            if (phase == 0) hold_off_request <= 1'b1;
            cols_used = (cols == 0) ? 1 : cols;
            rows_used = (rows == 0) ? 1 : rows;
            repeat (frames) begin
               send_frame(cols_used, cols_used * rows_used, $urandom_range(3) == 0);
               random_items += cols_used * rows_used + cols_used;
            end
         end
         phase++;
      end

      settle();
      if (failures == 0) begin
         $display("** grayscale_cross_erosion: PASSED **");
      end else begin
         $display("** grayscale_cross_erosion: FAILED **");
      end
      $finish;
   end

endmodule
